// File: rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// Shared types, field widths and codes for the gateway scan table.
// ----------------------------------------------------------------------------
package gst_pkg;

   localparam int ID_W   = 64;
   localparam int TIME_W = 32;
   localparam int RSSI_W = 8;
   localparam int CHAN_W = 6;
   localparam int SLOT_W = 3;
   localparam int ACT_W  = 2;
   localparam int SUM_W  = 10;   // three 8-bit signed readings
   localparam int CNT_W  = 2;    // up to three fresh readings

   localparam logic [CHAN_W-1:0]        FIRST_CHANNEL = 6'd37;
   localparam logic signed [RSSI_W-1:0] AVG_FLOOR     = -8'sd128;
   localparam logic [TIME_W-1:0]        MAX_AGE_RESET = 32'd1000000;

   // opcodes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   // result actions
   localparam logic [ACT_W-1:0] ACT_UPDATED  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_INSERTED = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REPLACED = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SELECT   = 2'd3;

   typedef struct packed {
      logic                     opcode;
      logic [ID_W-1:0]          gw_id;
      logic signed [RSSI_W-1:0] rssi_dbm;
      logic [CHAN_W-1:0]        channel;
      logic [TIME_W-1:0]        now_us;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [SLOT_W-1:0]        slot;
      logic [ID_W-1:0]          best_gw_id;
      logic                     best_valid;
      logic signed [RSSI_W-1:0] best_avg_rssi;
   } rsp_type;

   // per-entry summary from the evaluation stage
   typedef struct packed {
      logic                    match;     // id equals the request id
      logic                    live;      // nonzero id after the stale sweep
      logic                    present;   // nonzero id as read
      logic [TIME_W-1:0]       newest;    // newest timestamp after the sweep
      logic signed [SUM_W-1:0] sum;       // sum of fresh readings
      logic [CNT_W-1:0]        cnt;       // number of fresh readings
   } eval_type;

   // sum / cnt truncated toward zero; divide by 3 via reciprocal 171/512
   function automatic logic signed [RSSI_W-1:0] avg_div(
      input logic signed [SUM_W-1:0] sum,
      input logic [CNT_W-1:0]        cnt
   );
      logic                neg;
      logic [SUM_W-1:0]    mag;
      logic [SUM_W+7:0]    prod;
      logic [SUM_W-1:0]    q;
      logic [SUM_W-1:0]    res;
      neg  = sum[SUM_W-1];
      mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
      prod = (SUM_W+8)'(mag) * (SUM_W+8)'(171);
      case (cnt)
         2'd1: q = mag;
         2'd2: q = mag >> 1;
         2'd3: q = SUM_W'(prod >> 9);
         default: q = '0;
      endcase
      res = neg ? SUM_W'(-q) : q;
      return RSSI_W'(res);
   endfunction

endpackage

// File: rtl/gst_entry_eval.sv
// ----------------------------------------------------------------------------
// gst_entry_eval
// Looks at one table entry: match, staleness, newest time, fresh-reading sum,
// and the write-back word for an add pass.
// ----------------------------------------------------------------------------
module gst_entry_eval #(
   parameter int CHANNELS = 3
) (
   input  gst_pkg::req_type                  req,
   input  logic [gst_pkg::TIME_W-1:0]        max_age,
   input  logic [gst_pkg::ID_W+CHANNELS*(gst_pkg::TIME_W+gst_pkg::RSSI_W)-1:0] ent_word,
   output logic [gst_pkg::ID_W+CHANNELS*(gst_pkg::TIME_W+gst_pkg::RSSI_W)-1:0] wb_word,
   output logic [gst_pkg::ID_W+CHANNELS*(gst_pkg::TIME_W+gst_pkg::RSSI_W)-1:0] ins_word,
   output gst_pkg::eval_type                 res
);
   import gst_pkg::*;

   localparam int LANE_W = TIME_W + RSSI_W;
   localparam int ENT_W  = ID_W + CHANNELS * LANE_W;

   logic [CHAN_W-1:0]       chan_off;
   logic                    chan_ok;
   logic [ID_W-1:0]         ent_id;
   logic [TIME_W-1:0]       ts [CHANNELS];
   logic [TIME_W-1:0]       age [CHANNELS];
   logic [TIME_W-1:0]       newest;
   logic                    stale;
   logic                    match;
   logic signed [SUM_W-1:0] sum;
   logic [CNT_W-1:0]        cnt;
   logic [ENT_W-1:0]        upd_word;

   always_comb begin
      chan_off = req.channel - FIRST_CHANNEL;
      chan_ok  = (req.channel >= FIRST_CHANNEL) && (chan_off < CHAN_W'(CHANNELS));
      ent_id   = ent_word[CHANNELS*LANE_W +: ID_W];
      newest   = '0;
      sum      = '0;
      cnt      = '0;
      upd_word = ent_word;
      ins_word = '0;
      ins_word[CHANNELS*LANE_W +: ID_W] = req.gw_id;
      for (int c = 0; c < CHANNELS; c++) begin
         ts[c]  = ent_word[c*LANE_W +: TIME_W];
         age[c] = req.now_us - ts[c];
         if (ts[c] > newest) begin
            newest = ts[c];
         end
         if ((ts[c] != '0) && (age[c] <= max_age)) begin
            sum = sum + SUM_W'(signed'(ent_word[c*LANE_W+TIME_W +: RSSI_W]));
            cnt = cnt + CNT_W'(1);
         end
         if (chan_ok && (chan_off == CHAN_W'(c))) begin
            upd_word[c*LANE_W +: LANE_W] = {req.rssi_dbm, req.now_us};
            ins_word[c*LANE_W +: LANE_W] = {req.rssi_dbm, req.now_us};
         end
      end
      stale = (req.now_us - newest) > max_age;
      match = (ent_id == req.gw_id);

      if (match) begin
         wb_word = upd_word;
      end else if (stale) begin
         wb_word = '0;
      end else begin
         wb_word = ent_word;
      end

      res.match   = match;
      res.present = (ent_id != '0);
      res.live    = (ent_id != '0) && !stale;
      res.newest  = stale ? '0 : newest;
      res.sum     = sum;
      res.cnt     = cnt;
   end

endmodule

// File: rtl/gateway_scan_table_unit.sv
// ----------------------------------------------------------------------------
// gateway_scan_table_unit
// Gateway table with per-channel signal readings: add a scan report or
// select the gateway with the best average signal strength.
// ----------------------------------------------------------------------------
// One request at a time: req_ready is high only in idle; the single read port
//   walks the table one entry per cycle.
// An add with a zero id answers without touching the table.
// Reset: per-entry valid flags clear (table reads as empty, no clearing
//   pass); max_age_us returns to 1000000.
// ----------------------------------------------------------------------------
module gateway_scan_table_unit #(
   parameter int TABLE_ENTRIES = 8,
   parameter int CHANNELS      = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  gst_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output gst_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [gst_pkg::TIME_W-1:0]  csr_wr_data
);
   import gst_pkg::*;

   localparam int LANE_W = TIME_W + RSSI_W;
   localparam int ENT_W  = ID_W + CHANNELS * LANE_W;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ISS_W  = IDX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // --- control state ---
   state_type                  state_ff, state_in;
   logic [TIME_W-1:0]          max_age_ff, max_age_in;
   logic [ISS_W-1:0]           iss_cnt_ff, iss_cnt_in;
   logic                       rd_vld_ff, rd_vld_in;      // read data stage valid
   logic                       s2_vld_ff, s2_vld_in;      // accumulate stage valid
   logic [TABLE_ENTRIES-1:0]   ent_vld_ff, ent_vld_in;    // entry ever written
   logic                       rsp_valid_ff, rsp_valid_in;

   // --- payload ---
   req_type                    req_ff, req_in;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       rd_live_ff;
   logic [ENT_W-1:0]           rd_q_ff;
   logic [IDX_W-1:0]           s2_idx_ff;
   eval_type                   s2_eval_ff;
   logic [ID_W-1:0]            s2_id_ff;                  // id carried with the summary
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           found_slot_ff, found_slot_in;
   logic                       empty_ff, empty_in;
   logic [IDX_W-1:0]           empty_slot_ff, empty_slot_in;
   logic [TIME_W-1:0]          oldest_ff, oldest_in;
   logic [IDX_W-1:0]           old_slot_ff, old_slot_in;
   logic [ID_W-1:0]            best_id_ff, best_id_in;
   logic signed [RSSI_W-1:0]   best_avg_ff, best_avg_in;
   logic                       best_valid_ff, best_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   // --- table memory: id plus one time/strength lane per channel ---
   logic [ENT_W-1:0]           mem [TABLE_ENTRIES];

   logic                       req_fire;
   logic                       issue;
   logic [IDX_W-1:0]           rd_addr;
   logic                       out_free;
   logic                       fin_wr;
   logic [IDX_W-1:0]           tgt_slot;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [ENT_W-1:0]           wr_data;
   logic [ENT_W-1:0]           rd_word;
   logic [ENT_W-1:0]           wb_word;
   logic [ENT_W-1:0]           ins_word;
   eval_type                   eval_res;
   logic signed [RSSI_W-1:0]   avg;
   rsp_type                    rsp_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid && req_ready;

   // walk the table one entry per cycle
   assign issue   = (state_ff == ST_SCAN) && (iss_cnt_ff < ISS_W'(TABLE_ENTRIES));
   assign rd_addr = iss_cnt_ff[IDX_W-1:0];

   // entries never written read as empty
   assign rd_word = rd_live_ff ? rd_q_ff : '0;

   gst_entry_eval #(
      .CHANNELS (CHANNELS)
   ) u_eval (
      .req      (req_ff),
      .max_age  (max_age_ff),
      .ent_word (rd_word),
      .wb_word  (wb_word),
      .ins_word (ins_word),
      .res      (eval_res)
   );

   // Write port: add pass writes each entry back the cycle after its read
   // (matched entry updated, stale entry cleared); the insert/replace write
   // happens once the pipe has drained, so no two accesses overlap.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tgt_slot = empty_ff ? empty_slot_ff : old_slot_ff;
   assign fin_wr   = (state_ff == ST_FINISH) && out_free &&
                     (req_ff.opcode == OP_ADD) && !found_ff;
   assign wr_en    = (rd_vld_ff && (req_ff.opcode == OP_ADD)) || fin_wr;
   assign wr_addr  = fin_wr ? tgt_slot : rd_idx_ff;
   assign wr_data  = fin_wr ? ins_word : wb_word;

   assign avg = avg_div(s2_eval_ff.sum, s2_eval_ff.cnt);

   // response word
   always_comb begin
      rsp_next = '0;
      if (req_ff.opcode == OP_SELECT) begin
         rsp_next.action        = ACT_SELECT;
         rsp_next.best_gw_id    = best_id_ff;
         rsp_next.best_valid    = best_valid_ff;
         rsp_next.best_avg_rssi = best_valid_ff ? best_avg_ff : '0;
      end else if (found_ff) begin
         rsp_next.action = ACT_UPDATED;
         rsp_next.slot   = SLOT_W'(found_slot_ff);
      end else if (empty_ff) begin
         rsp_next.action = ACT_INSERTED;
         rsp_next.slot   = SLOT_W'(empty_slot_ff);
      end else begin
         rsp_next.action = ACT_REPLACED;
         rsp_next.slot   = SLOT_W'(old_slot_ff);
      end
   end

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      max_age_in    = csr_wr_en ? csr_wr_data : max_age_ff;
      iss_cnt_in    = issue ? iss_cnt_ff + ISS_W'(1) : iss_cnt_ff;
      rd_vld_in     = issue;
      s2_vld_in     = rd_vld_ff;
      ent_vld_in    = ent_vld_ff;
      if (wr_en) begin
         ent_vld_in[wr_addr] = 1'b1;
      end
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      req_in        = req_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      empty_in      = empty_ff;
      empty_slot_in = empty_slot_ff;
      oldest_in     = oldest_ff;
      old_slot_in   = old_slot_ff;
      best_id_in    = best_id_ff;
      best_avg_in   = best_avg_ff;
      best_valid_in = best_valid_ff;

      // fold one entry into the running results, in slot order
      if (s2_vld_ff) begin
         if (req_ff.opcode == OP_ADD) begin
            if (s2_eval_ff.match) begin
               if (!found_ff) begin
                  found_slot_in = s2_idx_ff;
               end
               found_in = 1'b1;
            end else begin
               if (!s2_eval_ff.live && !empty_ff) begin
                  empty_in      = 1'b1;
                  empty_slot_in = s2_idx_ff;
               end
               if (s2_eval_ff.live && (s2_eval_ff.newest < oldest_ff)) begin
                  oldest_in   = s2_eval_ff.newest;
                  old_slot_in = s2_idx_ff;
               end
            end
         end else if (s2_eval_ff.present && (s2_eval_ff.cnt != '0) &&
                      (avg > best_avg_ff)) begin
            // strict compare keeps the lowest slot on a tie
            best_avg_in   = avg;
            best_id_in    = s2_id_ff;
            best_valid_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in        = req_data;
               iss_cnt_in    = '0;
               found_in      = 1'b0;
               found_slot_in = '0;
               empty_in      = 1'b0;
               empty_slot_in = '0;
               oldest_in     = req_data.now_us;
               old_slot_in   = '0;
               best_id_in    = '0;
               best_avg_in   = AVG_FLOOR;
               best_valid_in = 1'b0;
               // zero id on add: no table access, answers as an update of slot 0
               if ((req_data.opcode == OP_ADD) && (req_data.gw_id == '0)) begin
                  found_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!issue && !rd_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_age_ff   <= MAX_AGE_RESET;
         iss_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         ent_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_age_ff   <= max_age_in;
         iss_cnt_ff   <= iss_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         s2_vld_ff    <= s2_vld_in;
         ent_vld_ff   <= ent_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rd_idx_ff     <= rd_addr;
      rd_live_ff    <= ent_vld_ff[rd_addr];
      s2_idx_ff     <= rd_idx_ff;
      s2_eval_ff    <= eval_res;
      s2_id_ff      <= rd_word[CHANNELS*LANE_W +: ID_W];
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      empty_ff      <= empty_in;
      empty_slot_ff <= empty_slot_in;
      oldest_ff     <= oldest_in;
      old_slot_ff   <= old_slot_in;
      best_id_ff    <= best_id_in;
      best_avg_ff   <= best_avg_in;
      best_valid_ff <= best_valid_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

endmodule
